[hdl/iesi_pkg.sv]
// Shared widths, constants and saturation helpers for the strapdown integrator.
package iesi_pkg;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic signed [31:0]       Q30_ONE   = 32'sh4000_0000;
   localparam logic signed [PROD_W-1:0] GRAVITY_Z = -66'sd642908;

   function automatic logic signed [PROD_W-1:0] ext32(input logic signed [31:0] x);
      return {{(PROD_W-32){x[31]}}, x};
   endfunction

   function automatic logic signed [PROD_W-1:0] ext48(input logic signed [47:0] x);
      return {{(PROD_W-48){x[47]}}, x};
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
      if (x > 66'sd2147483647) return 32'sh7fff_ffff;
      else if (x < -66'sd2147483648) return 32'sh8000_0000;
      else return x[31:0];
   endfunction

   // symmetric clamp for quaternion components
   function automatic logic signed [31:0] satq(input logic signed [PROD_W-1:0] x);
      if (x > 66'sd2147483647) return 32'sh7fff_ffff;
      else if (x < -66'sd2147483647) return 32'sh8000_0001;
      else return x[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [PROD_W-1:0] x);
      if (x > 66'sd140737488355327) return 48'sh7fff_ffff_ffff;
      else if (x < -66'sd140737488355328) return 48'sh8000_0000_0000;
      else return x[47:0];
   endfunction

endpackage

[hdl/iesi_mul.sv]
// Shared signed multiplier with a registered product.
module iesi_mul (
   input  logic                                 clock,
   input  logic signed [iesi_pkg::MUL_W-1:0]    mul_a,
   input  logic signed [iesi_pkg::MUL_W-1:0]    mul_b,
   output logic signed [iesi_pkg::PROD_W-1:0]   product
);
   import iesi_pkg::*;

   logic signed [PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= mul_a * mul_b;
   end

   assign product = product_ff;

endmodule

[hdl/imu_euler_strapdown_integrator.sv]
// Strapdown integrator top level: sequencer around one shared multiplier, root and divider.
// One sample at a time. The first sample after reset loads its attitude quaternion, clears
// position and velocity and goes straight to the result register without arithmetic. Every
// later sample runs 41 products on the one shared 33x33 multiplier, each issued and then
// accumulated and saturated, a 32-step bit-serial square root of the quaternion's sum of
// squares, four 31-step restoring divisions for the renormalization, and then loads the
// result register. When the stepped quaternion is all zero the divisions are skipped.
// req_tready is high only while the sequencer is idle; a finished result waits in its own
// register, so the next sample can be taken meanwhile, and the sequencer holds its own
// finished result until that register is free.
module imu_euler_strapdown_integrator (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, step_time, meas_qw, meas_qx,
   // meas_qy, meas_qz: 32 bits each from bit 0 up
   input  logic [351:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // pos_x, pos_y, pos_z (48 bits each), vel_x, vel_y, vel_z, att_w, att_x, att_y,
   // att_z (32 bits each) from bit 0 up
   output logic [367:0]  rsp_tdata
);
   import iesi_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   localparam logic [2:0] SH_30 = 3'd0;
   localparam logic [2:0] SH_29 = 3'd1;
   localparam logic [2:0] SH_24 = 3'd2;
   localparam logic [2:0] SH_16 = 3'd3;
   localparam logic [2:0] SH_0  = 3'd4;

   localparam logic [5:0] LAST_STEP = 6'd40;
   localparam logic [4:0] LAST_DIV  = 5'd30;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  step_ff, step_in;

   logic signed [31:0] acc_ff [3];
   logic signed [31:0] rate_ff [3];
   logic [31:0]        dt_ff;

   logic signed [47:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] att_ff [4];
   logic               started_ff;

   logic signed [31:0] c_ff [3];
   logic signed [31:0] d_ff [3];
   logic signed [31:0] h_ff [4];
   logic signed [31:0] qn_ff [4];
   logic signed [PROD_W-1:0] accum_ff;

   logic [63:0] sum_ff, root_ff, bit_ff;
   logic [31:0] rem_ff;
   logic [29:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic [1:0]  comp_ff;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [367:0] rsp_data_ff;

   // operand and accumulate control for the current step
   logic signed [31:0]       opa, opb;
   logic                     use_dt;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic [2:0]               sh_code;
   logic                     neg, first;
   logic signed [PROD_W-1:0] init;
   logic signed [PROD_W-1:0] product, term, base, sum_w;
   logic signed [MUL_W-1:0]  dt33;

   logic [63:0] trial_root;
   logic [32:0] trial_div;
   logic        div_ge;
   logic [30:0] mag_cur, mag_next;
   logic [30:0] quo_full;
   logic [31:0] n_root;

   logic accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign dt33       = {1'b0, dt_ff};
   assign n_root     = root_ff[31:0];
   assign mul_a      = {opa[31], opa};
   assign mul_b      = use_dt ? dt33 : {opb[31], opb};

   always_comb begin
      opa    = '0;
      opb    = '0;
      use_dt = 1'b0;
      sh_code = SH_0;
      neg   = 1'b0;
      first = 1'b0;
      init  = '0;
      case (step_ff)
         6'd0:  begin opa = att_ff[2]; opb = acc_ff[2]; sh_code = SH_30; first = 1'b1; end
         6'd1:  begin opa = att_ff[3]; opb = acc_ff[1]; sh_code = SH_30; neg = 1'b1; end
         6'd2:  begin opa = att_ff[3]; opb = acc_ff[0]; sh_code = SH_30; first = 1'b1; end
         6'd3:  begin opa = att_ff[1]; opb = acc_ff[2]; sh_code = SH_30; neg = 1'b1; end
         6'd4:  begin opa = att_ff[1]; opb = acc_ff[1]; sh_code = SH_30; first = 1'b1; end
         6'd5:  begin opa = att_ff[2]; opb = acc_ff[0]; sh_code = SH_30; neg = 1'b1; end
         6'd6:  begin
            opa = att_ff[0]; opb = c_ff[0]; sh_code = SH_29; first = 1'b1;
            init = ext32(acc_ff[0]);
         end
         6'd7:  begin opa = att_ff[2]; opb = c_ff[2]; sh_code = SH_29; end
         6'd8:  begin opa = att_ff[3]; opb = c_ff[1]; sh_code = SH_29; neg = 1'b1; end
         6'd9:  begin
            opa = att_ff[0]; opb = c_ff[1]; sh_code = SH_29; first = 1'b1;
            init = ext32(acc_ff[1]);
         end
         6'd10: begin opa = att_ff[3]; opb = c_ff[0]; sh_code = SH_29; end
         6'd11: begin opa = att_ff[1]; opb = c_ff[2]; sh_code = SH_29; neg = 1'b1; end
         6'd12: begin
            opa = att_ff[0]; opb = c_ff[2]; sh_code = SH_29; first = 1'b1;
            init = ext32(acc_ff[2]) + GRAVITY_Z;
         end
         6'd13: begin opa = att_ff[1]; opb = c_ff[1]; sh_code = SH_29; end
         6'd14: begin opa = att_ff[2]; opb = c_ff[0]; sh_code = SH_29; neg = 1'b1; end
         6'd15: begin
            opa = vel_ff[0]; use_dt = 1'b1; sh_code = SH_24; first = 1'b1;
            init = ext48(pos_ff[0]);
         end
         6'd16: begin
            opa = vel_ff[1]; use_dt = 1'b1; sh_code = SH_24; first = 1'b1;
            init = ext48(pos_ff[1]);
         end
         6'd17: begin
            opa = vel_ff[2]; use_dt = 1'b1; sh_code = SH_24; first = 1'b1;
            init = ext48(pos_ff[2]);
         end
         6'd18: begin
            opa = d_ff[0]; use_dt = 1'b1; sh_code = SH_24; first = 1'b1;
            init = ext32(vel_ff[0]);
         end
         6'd19: begin
            opa = d_ff[1]; use_dt = 1'b1; sh_code = SH_24; first = 1'b1;
            init = ext32(vel_ff[1]);
         end
         6'd20: begin
            opa = d_ff[2]; use_dt = 1'b1; sh_code = SH_24; first = 1'b1;
            init = ext32(vel_ff[2]);
         end
         6'd21: begin
            opa = att_ff[1]; opb = rate_ff[0]; sh_code = SH_16; neg = 1'b1; first = 1'b1;
         end
         6'd22: begin opa = att_ff[2]; opb = rate_ff[1]; sh_code = SH_16; neg = 1'b1; end
         6'd23: begin opa = att_ff[3]; opb = rate_ff[2]; sh_code = SH_16; neg = 1'b1; end
         6'd24: begin opa = att_ff[0]; opb = rate_ff[0]; sh_code = SH_16; first = 1'b1; end
         6'd25: begin opa = att_ff[2]; opb = rate_ff[2]; sh_code = SH_16; end
         6'd26: begin opa = att_ff[3]; opb = rate_ff[1]; sh_code = SH_16; neg = 1'b1; end
         6'd27: begin opa = att_ff[0]; opb = rate_ff[1]; sh_code = SH_16; first = 1'b1; end
         6'd28: begin opa = att_ff[1]; opb = rate_ff[2]; sh_code = SH_16; neg = 1'b1; end
         6'd29: begin opa = att_ff[3]; opb = rate_ff[0]; sh_code = SH_16; end
         6'd30: begin opa = att_ff[0]; opb = rate_ff[2]; sh_code = SH_16; first = 1'b1; end
         6'd31: begin opa = att_ff[1]; opb = rate_ff[1]; sh_code = SH_16; end
         6'd32: begin opa = att_ff[2]; opb = rate_ff[0]; sh_code = SH_16; neg = 1'b1; end
         6'd33: begin
            opa = h_ff[0]; use_dt = 1'b1; sh_code = SH_24; first = 1'b1;
            init = ext32(att_ff[0]);
         end
         6'd34: begin
            opa = h_ff[1]; use_dt = 1'b1; sh_code = SH_24; first = 1'b1;
            init = ext32(att_ff[1]);
         end
         6'd35: begin
            opa = h_ff[2]; use_dt = 1'b1; sh_code = SH_24; first = 1'b1;
            init = ext32(att_ff[2]);
         end
         6'd36: begin
            opa = h_ff[3]; use_dt = 1'b1; sh_code = SH_24; first = 1'b1;
            init = ext32(att_ff[3]);
         end
         6'd37: begin opa = qn_ff[0]; opb = qn_ff[0]; first = 1'b1; end
         6'd38: begin opa = qn_ff[1]; opb = qn_ff[1]; end
         6'd39: begin opa = qn_ff[2]; opb = qn_ff[2]; end
         6'd40: begin opa = qn_ff[3]; opb = qn_ff[3]; end
         default: begin end
      endcase
   end

   iesi_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   always_comb begin
      case (sh_code)
         SH_30:   term = product >>> 30;
         SH_29:   term = product >>> 29;
         SH_24:   term = product >>> 24;
         SH_16:   term = product >>> 16;
         default: term = product;
      endcase
      base  = first ? init : accum_ff;
      sum_w = neg ? base - term : base + term;
   end

   assign trial_root = root_ff + bit_ff;
   assign mag_cur    = qn_ff[comp_ff][31] ? 31'(-qn_ff[comp_ff]) : qn_ff[comp_ff][30:0];
   assign mag_next   = qn_ff[2'(comp_ff + 2'd1)][31] ? 31'(-qn_ff[2'(comp_ff + 2'd1)])
                                                     : qn_ff[2'(comp_ff + 2'd1)][30:0];
   // shift the dividend in: its only nonzero bit left is mag[0], then zeros
   assign trial_div  = {rem_ff, (cnt_ff == 5'd0) ? mag_cur[0] : 1'b0};
   assign div_ge     = trial_div >= {1'b0, n_root};
   assign quo_full   = {quo_ff, div_ge};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = started_ff ? ST_MUL : ST_FIN;
         ST_MUL:  state_in = ST_ACC;
         ST_ACC: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_SQRT;
            end else begin
               state_in = ST_MUL;
               step_in  = step_ff + 6'd1;
            end
         end
         ST_SQRT: if (bit_ff[0]) state_in = ST_DIV;
         ST_DIV: begin
            if (n_root == 32'd0) state_in = ST_FIN;
            else if (cnt_ff == LAST_DIV && comp_ff == 2'd3) state_in = ST_FIN;
         end
         ST_FIN:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_IDLE) step_in = 6'd0;
   end

   // load a finished result when the register is free, drop it after its transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready)) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 6'd0;
         started_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
         end
         att_ff[0] <= Q30_ONE;
         att_ff[1] <= '0;
         att_ff[2] <= '0;
         att_ff[3] <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  for (int i = 0; i < 3; i++) begin
                     acc_ff[i]  <= req_tdata[32*i +: 32];
                     rate_ff[i] <= req_tdata[96 + 32*i +: 32];
                  end
                  dt_ff <= req_tdata[223:192];
                  if (!started_ff) begin
                     started_ff <= 1'b1;
                     for (int i = 0; i < 4; i++) att_ff[i] <= req_tdata[224 + 32*i +: 32];
                     for (int i = 0; i < 3; i++) begin
                        pos_ff[i] <= '0;
                        vel_ff[i] <= '0;
                     end
                  end
               end
            end
            ST_ACC: begin
               accum_ff <= sum_w;
               case (step_ff) inside
                  6'd1:           c_ff[0] <= sat32(sum_w);
                  6'd3:           c_ff[1] <= sat32(sum_w);
                  6'd5:           c_ff[2] <= sat32(sum_w);
                  6'd8:           d_ff[0] <= sat32(sum_w);
                  6'd11:          d_ff[1] <= sat32(sum_w);
                  6'd14:          d_ff[2] <= sat32(sum_w);
                  [6'd15:6'd17]:  pos_ff[2'(step_ff - 6'd15)] <= sat48(sum_w);
                  [6'd18:6'd20]:  vel_ff[2'(step_ff - 6'd18)] <= sat32(sum_w);
                  6'd23:          h_ff[0] <= sat32(sum_w >>> 1);
                  6'd26:          h_ff[1] <= sat32(sum_w >>> 1);
                  6'd29:          h_ff[2] <= sat32(sum_w >>> 1);
                  6'd32:          h_ff[3] <= sat32(sum_w >>> 1);
                  [6'd33:6'd36]:  qn_ff[2'(step_ff - 6'd33)] <= satq(sum_w);
                  LAST_STEP: begin
                     sum_ff  <= sum_w[63:0];
                     root_ff <= '0;
                     bit_ff  <= 64'd1 << 62;
                  end
                  default: begin end
               endcase
            end
            ST_SQRT: begin
               if (sum_ff >= trial_root) begin
                  sum_ff  <= sum_ff - trial_root;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) begin
                  comp_ff <= 2'd0;
                  cnt_ff  <= 5'd0;
                  rem_ff  <= {2'b00, qn_ff[0][31] ? 30'(31'(-qn_ff[0]) >> 1)
                                                  : qn_ff[0][30:1]};
               end
            end
            ST_DIV: begin
               if (n_root == 32'd0) begin
                  // all stepped components are zero: no division
                  for (int i = 0; i < 4; i++) att_ff[i] <= '0;
               end else begin
                  quo_ff <= quo_full[29:0];
                  if (cnt_ff == LAST_DIV) begin
                     att_ff[comp_ff] <= qn_ff[comp_ff][31] ? -$signed({1'b0, quo_full})
                                                          : $signed({1'b0, quo_full});
                     comp_ff <= comp_ff + 2'd1;
                     cnt_ff  <= 5'd0;
                     rem_ff  <= {2'b00, mag_next[30:1]};
                  end else begin
                     rem_ff <= div_ge ? 32'(trial_div - {1'b0, n_root}) : trial_div[31:0];
                     cnt_ff <= cnt_ff + 5'd1;
                  end
               end
            end
            ST_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  for (int i = 0; i < 3; i++) begin
                     rsp_data_ff[48*i +: 48]       <= pos_ff[i];
                     rsp_data_ff[144 + 32*i +: 32] <= vel_ff[i];
                  end
                  for (int i = 0; i < 4; i++) rsp_data_ff[240 + 32*i +: 32] <= att_ff[i];
               end
            end
            default: begin end
         endcase
      end
   end

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("sequencer took a sample and stayed ready");

   a_started_sticks: assert property (@(posedge clock) disable iff (reset)
      started_ff |=> started_ff)
      else $error("started flag dropped outside reset");

   a_root_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> $onehot(bit_ff))
      else $error("root trial bit is not one-hot");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < n_root) || (n_root == 32'd0))
      else $error("divider remainder reached the divisor");

endmodule
